>>> src/stable_insertion_sorter_unit_assert.svh
// ----------------------------------------------------------------------------
// stable_insertion_sorter_unit_assert.svh
// Assertion macros used by the sorter checker.
// ----------------------------------------------------------------------------
`ifndef STABLE_INSERTION_SORTER_UNIT_ASSERT_SVH
`define STABLE_INSERTION_SORTER_UNIT_ASSERT_SVH

// same-cycle implication
`define SIS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SIS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/sis_pkg.sv
// ----------------------------------------------------------------------------
// sis_pkg
// Types and constants for the stable insertion sorter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sis_pkg;

  localparam int ID_W      = 30;
  localparam int BYTE_W    = 8;
  localparam int DEPTH_DEF = 64;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [BYTE_W-1:0] copies;
    logic [BYTE_W-1:0] key;
  } entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_INSERT,
    ST_EMIT
  } state_t;

endpackage

`default_nettype wire

>>> src/stable_insertion_sorter_unit.sv
// ----------------------------------------------------------------------------
// stable_insertion_sorter_unit
// Stable ascending insertion sort of records held in one entry memory.
// ----------------------------------------------------------------------------
// channel   | handshake                | fields
// record in | start & !busy            | record_id, copies, sort_key, last_record
// result    | result_valid             | out_id, out_copies, out_key, out_last,
//           |                          | overflowed
//
// Insert: each stored entry with a larger key moves up one slot, then the record
// is written, through the single read/write port pair of the entry memory.
// Emit on last beat: the n stored entries go out one beat per cycle.
// A record beyond DEPTH is dropped in its accept cycle.
// Reset clears the entry count and overflow flag; the memory is not cleared.
// The receiver cannot stall; busy covers the final result beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module stable_insertion_sorter_unit #(
  parameter int DEPTH = sis_pkg::DEPTH_DEF
) (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         start,
  output logic                        busy,
  input  wire  [sis_pkg::ID_W-1:0]    record_id,
  input  wire  [sis_pkg::BYTE_W-1:0]  copies,
  input  wire  [sis_pkg::BYTE_W-1:0]  sort_key,
  input  wire                         last_record,
  output logic                        result_valid,
  output logic [sis_pkg::ID_W-1:0]    out_id,
  output logic [sis_pkg::BYTE_W-1:0]  out_copies,
  output logic [sis_pkg::BYTE_W-1:0]  out_key,
  output logic                        out_last,
  output logic                        overflowed
);

  import sis_pkg::*;

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  entry_t mem [DEPTH];
  entry_t rdata;

  state_t state, state_next;

  logic [CNT_W-1:0] count;
  logic             overflow;
  logic [IDX_W-1:0] pos;
  logic [IDX_W-1:0] emit_idx;
  entry_t           rec;
  logic             rec_last;
  logic             strobe;
  logic             last_r;
  logic             ovf_r;

  logic             accept;
  logic             full;
  logic             shift;
  logic             emit_end;
  logic [CNT_W-1:0] cnt_m1;
  logic [IDX_W-1:0] pos_m1;
  logic [IDX_W-1:0] pos_m2;

  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  entry_t           wr_data;

  assign accept   = start & ~busy;
  assign full     = (count == CNT_W'(DEPTH));
  assign cnt_m1   = count - CNT_W'(1);
  assign pos_m1   = pos - IDX_W'(1);
  assign pos_m2   = pos - IDX_W'(2);
  assign shift    = (pos != '0) && (rdata.key > rec.key);
  assign emit_end = (emit_idx == cnt_m1[IDX_W-1:0]);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (!full) begin
            state_next = ST_INSERT;
          end else if (last_record) begin
            state_next = ST_EMIT;
          end
        end
      end
      ST_INSERT: begin
        if (!shift) begin
          state_next = rec_last ? ST_EMIT : ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (emit_end) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // memory control
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = pos;
    wr_data = rec;
    unique case (state)
      ST_IDLE: begin
        if (accept && !full && count != '0) begin
          rd_en   = 1'b1;
          rd_addr = cnt_m1[IDX_W-1:0];
        end
      end
      ST_INSERT: begin
        wr_en = 1'b1;
        if (shift) begin
          wr_data = rdata;
          if (pos > IDX_W'(1)) begin
            rd_en   = 1'b1;
            rd_addr = pos_m2;
          end
        end
      end
      ST_EMIT: begin
        rd_en   = 1'b1;
        rd_addr = emit_idx;
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      count    <= '0;
      overflow <= 1'b0;
      strobe   <= 1'b0;
    end else begin
      state  <= state_next;
      strobe <= (state == ST_EMIT);
      unique case (state)
        ST_IDLE: begin
          if (accept && full) begin
            overflow <= 1'b1;
          end
        end
        ST_INSERT: begin
          if (!shift) begin
            count <= count + CNT_W'(1);
          end
        end
        ST_EMIT: begin
          if (emit_end) begin
            count    <= '0;
            overflow <= 1'b0;
          end
        end
        default: begin
          count <= count;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && accept) begin
      rec.id     <= record_id;
      rec.copies <= copies;
      rec.key    <= sort_key;
      rec_last   <= last_record;
      pos        <= count[IDX_W-1:0];
      emit_idx   <= '0;
    end
    if (state == ST_INSERT) begin
      if (shift) begin
        pos <= pos_m1;
      end
      emit_idx <= '0;
    end
    if (state == ST_EMIT) begin
      emit_idx <= emit_idx + IDX_W'(1);
      last_r   <= emit_end;
      ovf_r    <= overflow;
    end
  end

  assign busy         = (state != ST_IDLE) | strobe;
  assign result_valid = strobe;
  assign out_id       = rdata.id;
  assign out_copies   = rdata.copies;
  assign out_key      = rdata.key;
  assign out_last     = strobe & last_r;
  assign overflowed   = ovf_r;

endmodule

`default_nettype wire

>>> src/sis_checker.sv
// ----------------------------------------------------------------------------
// sis_checker
// Port-level checks on the result beats of the insertion sorter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "stable_insertion_sorter_unit_assert.svh"

module sis_checker (
  input wire clk,
  input wire rst,
  input wire busy,
  input wire result_valid,
  input wire out_last,
  input wire overflowed
);

  `SIS_ASSERT_SAME(a_last_on_beat, clk, rst, out_last, result_valid, "out_last without beat")
  `SIS_ASSERT_NEXT(a_run_contiguous, clk, rst, result_valid && !out_last, result_valid, "gap in run")
  `SIS_ASSERT_NEXT(a_run_ends, clk, rst, result_valid && out_last, !result_valid, "beat after last")
  `SIS_ASSERT_NEXT(a_ovf_steady, clk, rst, result_valid && !out_last, $stable(overflowed), "ovf changed in run")
  `SIS_ASSERT_NEXT(a_idle_quiet, clk, rst, !busy, !result_valid, "beat from idle")

endmodule

bind stable_insertion_sorter_unit sis_checker u_sis_checker (
  .clk          (clk),
  .rst          (rst),
  .busy         (busy),
  .result_valid (result_valid),
  .out_last     (out_last),
  .overflowed   (overflowed)
);

`default_nettype wire
